@@ hdl/slt_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted list table package
// Shared sizes, operation and status codes, and the controller/datapath
// command and status types.
// ----------------------------------------------------------------------------
package slt_pkg;

  // table size and derived widths
  localparam int DEPTH  = 32;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // field widths of the channels
  localparam int MODE_W    = 2;
  localparam int VAL_W     = 32;
  localparam int POS_IN_W  = 5;
  localparam int STAT_W    = 2;
  localparam int POS_OUT_W = 6;
  localparam int SUM_W     = 37;

  // operation selected by the mode field
  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_FIND   = 2'd2,
    MODE_QUERY  = 2'd3
  } mode_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NO_ENTRY  = 2'd2,
    ST_NOT_FOUND = 2'd3
  } res_stat_t;

  // datapath commands issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_INS,
    OP_DEL_FIRST,
    OP_DEL_STEP,
    OP_FIND,
    OP_TAIL_RD,
    OP_TAIL_LD,
    OP_RESULT
  } dp_op_t;

  // datapath status seen by the controller
  typedef struct packed {
    mode_t mode;        // mode of the offered transaction
    logic  full;        // table holds DEPTH entries
    logic  pos_bad;     // offered delete position is past the end
    logic  ins_stop;    // insert slot found at current index
    logic  last_next;   // index + 1 equals count
    logic  last_next2;  // index + 2 equals count
    logic  find_done;   // find hit or ran past the end
    logic  out_busy;    // result register holds an untaken transaction
  } dp_stat_t;

endpackage

@@ hdl/slt_if.sv @@
// ----------------------------------------------------------------------------
// Sorted list table channels
// Valid/ready stream interfaces for the request and the result channel.
// ----------------------------------------------------------------------------
interface slt_in_if;
  import slt_pkg::*;

  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [VAL_W-1:0]    value;
  logic [POS_IN_W-1:0] position_in;

  modport source (output valid, output mode, output value, output position_in,
                  input ready);
  modport sink   (input valid, input mode, input value, input position_in,
                  output ready);
endinterface

interface slt_out_if;
  import slt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [STAT_W-1:0]    status;
  logic [POS_OUT_W-1:0] position_out;
  logic [POS_OUT_W-1:0] entry_count;
  logic [SUM_W-1:0]     total;
  logic [VAL_W-1:0]     largest;

  modport source (output valid, output status, output position_out,
                  output entry_count, output total, output largest,
                  input ready);
  modport sink   (input valid, input status, input position_out,
                  input entry_count, input total, input largest,
                  output ready);
endinterface

@@ hdl/slt_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module slt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/slt_datapath.sv @@
// ----------------------------------------------------------------------------
// Sorted list table datapath
// Entry RAM, scan index, count, running sum, largest value and the result
// register, driven one command per cycle by the controller.
// ----------------------------------------------------------------------------
module slt_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  slt_pkg::dp_op_t                op,
  output slt_pkg::dp_stat_t              stat,
  input  logic [slt_pkg::MODE_W-1:0]     in_mode,
  input  logic [slt_pkg::VAL_W-1:0]      in_value,
  input  logic [slt_pkg::POS_IN_W-1:0]   in_position_in,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [slt_pkg::STAT_W-1:0]     out_status,
  output logic [slt_pkg::POS_OUT_W-1:0]  out_position_out,
  output logic [slt_pkg::POS_OUT_W-1:0]  out_entry_count,
  output logic [slt_pkg::SUM_W-1:0]      out_total,
  output logic [slt_pkg::VAL_W-1:0]      out_largest
);
  import slt_pkg::*;

  // working registers
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [VAL_W-1:0]  largest_r, largest_nxt;
  res_stat_t         res_r, res_nxt;
  logic [CNT_W-1:0]  posout_r, posout_nxt;

  // result register
  logic                 out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]    out_status_r;
  logic [POS_OUT_W-1:0] out_position_r;
  logic [POS_OUT_W-1:0] out_count_r;
  logic [SUM_W-1:0]     out_total_r;
  logic [VAL_W-1:0]     out_largest_r;

  // RAM port
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [VAL_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [VAL_W-1:0]  ram_rdata;

  // index arithmetic
  logic [CNT_W-1:0] idx_inc, idx_inc2, idx_dec, idx_dec2, cnt_inc, cnt_dec, pos_ext;
  logic [SUM_W-1:0] val_ext, rdata_ext;
  mode_t            mode_in;
  logic             find_end, find_hit;

  slt_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign idx_inc   = idx_r + CNT_W'(1);
  assign idx_inc2  = idx_r + CNT_W'(2);
  assign idx_dec   = idx_r - CNT_W'(1);
  assign idx_dec2  = idx_r - CNT_W'(2);
  assign cnt_inc   = count_r + CNT_W'(1);
  assign cnt_dec   = count_r - CNT_W'(1);
  assign pos_ext   = CNT_W'(in_position_in);
  assign mode_in   = mode_t'(in_mode);
  assign val_ext   = {{(SUM_W-VAL_W){val_r[VAL_W-1]}}, val_r};
  assign rdata_ext = {{(SUM_W-VAL_W){ram_rdata[VAL_W-1]}}, ram_rdata};
  assign find_end  = (idx_r == count_r);
  assign find_hit  = (ram_rdata == val_r);

  // status toward the controller
  always_comb begin
    stat.mode       = mode_in;
    stat.full       = (count_r == CNT_W'(DEPTH));
    stat.pos_bad    = (pos_ext >= count_r);
    stat.ins_stop   = (idx_r == '0) || ($signed(ram_rdata) <= $signed(val_r));
    stat.last_next  = (idx_inc == count_r);
    stat.last_next2 = (idx_inc2 == count_r);
    stat.find_done  = find_end || find_hit;
    stat.out_busy   = out_valid_r && !out_ready;
  end

  // execute one command
  always_comb begin
    val_nxt     = val_r;
    idx_nxt     = idx_r;
    count_nxt   = count_r;
    sum_nxt     = sum_r;
    largest_nxt = largest_r;
    res_nxt     = res_r;
    posout_nxt  = posout_r;
    ram_we      = 1'b0;
    ram_waddr   = idx_r[ADDR_W-1:0];
    ram_wdata   = val_r;
    ram_raddr   = idx_r[ADDR_W-1:0];
    unique case (op)
      OP_NONE: begin
      end
      OP_LOAD: begin
        // latch the transaction and, except for a query, start the first read
        val_nxt    = in_value;
        posout_nxt = '0;
        res_nxt    = ST_OK;
        unique case (mode_in)
          MODE_INSERT: begin
            idx_nxt   = count_r;
            ram_raddr = cnt_dec[ADDR_W-1:0];
            if (stat.full) begin
              res_nxt = ST_FULL;
            end
          end
          MODE_DELETE: begin
            idx_nxt   = pos_ext;
            ram_raddr = pos_ext[ADDR_W-1:0];
            if (stat.pos_bad) begin
              res_nxt = ST_NO_ENTRY;
            end else begin
              posout_nxt = pos_ext;
            end
          end
          MODE_FIND: begin
            idx_nxt   = '0;
            ram_raddr = '0;
          end
          MODE_QUERY: begin
            idx_nxt = '0;
            if (count_r == '0) begin
              res_nxt = ST_NO_ENTRY;
            end
          end
        endcase
      end
      OP_INS: begin
        // move larger entries up one slot, then drop the value in
        ram_we = 1'b1;
        if (stat.ins_stop) begin
          ram_wdata  = val_r;
          posout_nxt = idx_r;
          count_nxt  = cnt_inc;
          sum_nxt    = sum_r + val_ext;
        end else begin
          ram_wdata = ram_rdata;
          idx_nxt   = idx_dec;
          ram_raddr = idx_dec2[ADDR_W-1:0];
        end
      end
      OP_DEL_FIRST: begin
        // take the removed entry out of the sum
        sum_nxt   = sum_r - rdata_ext;
        ram_raddr = idx_inc[ADDR_W-1:0];
        if (stat.last_next) begin
          count_nxt = cnt_dec;
        end
      end
      OP_DEL_STEP: begin
        // close the gap one entry at a time
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        idx_nxt   = idx_inc;
        ram_raddr = idx_inc2[ADDR_W-1:0];
        if (stat.last_next2) begin
          count_nxt = cnt_dec;
        end
      end
      OP_FIND: begin
        // compare the current entry, advance on a miss
        if (find_end) begin
          res_nxt    = ST_NOT_FOUND;
          posout_nxt = idx_r;
        end else if (find_hit) begin
          posout_nxt = idx_r;
        end else begin
          idx_nxt   = idx_inc;
          ram_raddr = idx_inc[ADDR_W-1:0];
        end
      end
      OP_TAIL_RD: begin
        ram_raddr = cnt_dec[ADDR_W-1:0];
      end
      OP_TAIL_LD: begin
        largest_nxt = (count_r == '0) ? '0 : ram_rdata;
      end
      OP_RESULT: begin
      end
    endcase
  end

  // result register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (op == OP_RESULT) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      sum_r       <= '0;
      largest_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      largest_r   <= largest_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r    <= val_nxt;
    idx_r    <= idx_nxt;
    res_r    <= res_nxt;
    posout_r <= posout_nxt;
    if (op == OP_RESULT) begin
      out_status_r   <= res_r;
      out_position_r <= POS_OUT_W'(posout_r);
      out_count_r    <= POS_OUT_W'(count_r);
      out_total_r    <= sum_r;
      out_largest_r  <= largest_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_position_out = out_position_r;
  assign out_entry_count  = out_count_r;
  assign out_total        = out_total_r;
  assign out_largest      = out_largest_r;

endmodule

@@ hdl/slt_ctrl.sv @@
// ----------------------------------------------------------------------------
// Sorted list table controller
// Sequences insert, delete, find and query over the datapath, one command
// per cycle.
// ----------------------------------------------------------------------------
module slt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  slt_pkg::dp_stat_t stat,
  output slt_pkg::dp_op_t   op
);
  import slt_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_INS     = 8'b0000_0010,
    S_DEL     = 8'b0000_0100,
    S_SHIFT   = 8'b0000_1000,
    S_FIND    = 8'b0001_0000,
    S_TAIL_RD = 8'b0010_0000,
    S_TAIL    = 8'b0100_0000,
    S_DONE    = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // next state and command
  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op = OP_LOAD;
          unique case (stat.mode)
            MODE_INSERT: state_nxt = stat.full    ? S_DONE : S_INS;
            MODE_DELETE: state_nxt = stat.pos_bad ? S_DONE : S_DEL;
            MODE_FIND:   state_nxt = S_FIND;
            MODE_QUERY:  state_nxt = S_DONE;
          endcase
        end
      end
      S_INS: begin
        op = OP_INS;
        if (stat.ins_stop) begin
          state_nxt = S_TAIL_RD;
        end
      end
      S_DEL: begin
        op        = OP_DEL_FIRST;
        state_nxt = stat.last_next ? S_TAIL_RD : S_SHIFT;
      end
      S_SHIFT: begin
        op = OP_DEL_STEP;
        if (stat.last_next2) begin
          state_nxt = S_TAIL_RD;
        end
      end
      S_FIND: begin
        op = OP_FIND;
        if (stat.find_done) begin
          state_nxt = S_DONE;
        end
      end
      S_TAIL_RD: begin
        op        = OP_TAIL_RD;
        state_nxt = S_TAIL;
      end
      S_TAIL: begin
        op        = OP_TAIL_LD;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // hold until the result register is free
        if (!stat.out_busy) begin
          op        = OP_RESULT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ hdl/sorted_list_table_unit.sv @@
// Throughput: one transaction at a time; the scan and shift run one entry per cycle,
// bounded by the single read port of the entry RAM.
// Reset clears the controller, count, sum, largest value and result valid;
// the entry RAM is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// Sorted list table unit
// Bounded ascending list of signed values with insert, delete at position,
// find and count/sum/max query.
// ----------------------------------------------------------------------------
module sorted_list_table_unit (
  input logic      clk,
  input logic      rst_n,
  slt_in_if.sink   in_chan,
  slt_out_if.source out_chan
);
  import slt_pkg::*;

  dp_op_t   op;
  dp_stat_t stat;

  slt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .op       (op)
  );

  slt_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .op               (op),
    .stat             (stat),
    .in_mode          (in_chan.mode),
    .in_value         (in_chan.value),
    .in_position_in   (in_chan.position_in),
    .out_ready        (out_chan.ready),
    .out_valid        (out_chan.valid),
    .out_status       (out_chan.status),
    .out_position_out (out_chan.position_out),
    .out_entry_count  (out_chan.entry_count),
    .out_total        (out_chan.total),
    .out_largest      (out_chan.largest)
  );

  // one transaction in flight: no accept right after an accept
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("second transaction accepted while busy");

  // count never exceeds the table size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.entry_count <= POS_OUT_W'(DEPTH)))
    else $error("entry count beyond table size");

  // full status only with a full table
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (out_chan.status == ST_FULL))
      |-> (out_chan.entry_count == POS_OUT_W'(DEPTH)))
    else $error("full status with free room");

  // an empty table reports zero sum and zero largest
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (out_chan.entry_count == '0))
      |-> ((out_chan.total == '0) && (out_chan.largest == '0)))
    else $error("empty table with nonzero sum or largest");

endmodule
